// ===== rtl/olc_pkg.sv =====
// Shared types and constants of the occupancy lamp controller.
// Used by olc_front, olc_queue, olc_back and the top level.
`default_nettype none

package olc_pkg;

  // Time stamps and elapsed-time arithmetic wrap at this width
  localparam int TIME_BITS = 32;
  localparam int CFG_BITS  = 16;

  // Item queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Report slots per item
  localparam int MAX_REPORTS = 3;
  localparam int REP_IDX_W   = $clog2(MAX_REPORTS);
  localparam int REP_CNT_W   = $clog2(MAX_REPORTS + 1);

  // Stream operation selector
  localparam logic OPERATION_POLL    = 1'b0;
  localparam logic OPERATION_COMMAND = 1'b1;

  // Lamp command bytes
  localparam logic [7:0] CMD_MANUAL_ON = 8'hFF;
  localparam logic [7:0] CMD_OFF       = 8'h00;
  localparam logic [7:0] CMD_ON        = 8'h01;

  // Configuration register indexes
  localparam logic [1:0] CFG_HOLD_TIME     = 2'd0;
  localparam logic [1:0] CFG_FAULT_CONFIRM = 2'd1;
  localparam logic [1:0] CFG_FAULT_CLEAR   = 2'd2;
  localparam logic [1:0] CFG_INITIAL_FAULT = 2'd3;

  // Reset values of the configuration registers
  localparam logic [CFG_BITS-1:0] HOLD_TIME_RESET     = 16'd10000;
  localparam logic [CFG_BITS-1:0] FAULT_CONFIRM_RESET = 16'd3000;
  localparam logic [CFG_BITS-1:0] FAULT_CLEAR_RESET   = 16'd3000;

  // Report kinds
  typedef enum logic [1:0] {
    REPORT_LAMP   = 2'd0,
    REPORT_MOTION = 2'd1,
    REPORT_FAULT  = 2'd2
  } report_kind_t;

  // Classified work item
  typedef enum logic [1:0] {
    ITEM_POLL      = 2'd0,
    ITEM_MANUAL_ON = 2'd1,
    ITEM_OFF       = 2'd2,
    ITEM_ON        = 2'd3
  } item_kind_t;

  typedef struct packed {
    item_kind_t           kind;
    logic [TIME_BITS-1:0] now_ms;
    logic                 motion_seen;
    logic                 lamp_dark_fault;
  } item_t;

  // One pending report
  typedef struct packed {
    report_kind_t kind;
    logic         value;
  } report_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [CFG_BITS-1:0] hold_time_ms;
    logic [CFG_BITS-1:0] fault_confirm_ms;
    logic [CFG_BITS-1:0] fault_clear_ms;
    logic                initial_fault;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/occupancy_lamp_controller_unit.sv =====
// Top level of the occupancy lamp controller: stream ports, configuration
// registers, front end, item queue and back end. Depends on olc_pkg.
`default_nettype none

// An item is taken and classified into a front register and passed
// through a four-entry queue to the back end. The back end takes an item and
// then sends its reports one per cycle while the output is not stalled, up to
// three per item from its report buffer; it can take the next item as the last
// report is loaded into the output register. The queue and the front register
// hold items while reports wait on a stalled output; once both are full the
// input stalls. Ignored commands (unknown byte or zero length) are dropped by
// the front end and give no transaction out. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while idle, as the block does not enforce it.

module occupancy_lamp_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] now_ms, [32] motion_seen, [33] lamp_dark_fault,
  // [41:34] command_byte, [47:42] command_length
  input  wire logic [47:0] s_axis_tdata,
  // [0] operation
  input  wire logic        s_axis_tuser,
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] report_value, [1] lamp_on, [2] override_active, [7:3] zero
  output logic [7:0]       m_axis_tdata,
  // [1:0] report_kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  olc_pkg::cfg_t    cfg;
  logic             push_valid;
  logic             push_ready;
  olc_pkg::item_t   push_item;
  logic             pop_valid;
  logic             pop_ready;
  olc_pkg::item_t   pop_item;
  olc_pkg::report_t out_report;
  logic             out_lamp_on;
  logic             out_override;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_time_ms     <= olc_pkg::HOLD_TIME_RESET;
      cfg.fault_confirm_ms <= olc_pkg::FAULT_CONFIRM_RESET;
      cfg.fault_clear_ms   <= olc_pkg::FAULT_CLEAR_RESET;
      cfg.initial_fault    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        olc_pkg::CFG_HOLD_TIME:     cfg.hold_time_ms     <= cfg_data;
        olc_pkg::CFG_FAULT_CONFIRM: cfg.fault_confirm_ms <= cfg_data;
        olc_pkg::CFG_FAULT_CLEAR:   cfg.fault_clear_ms   <= cfg_data;
        olc_pkg::CFG_INITIAL_FAULT: cfg.initial_fault    <= cfg_data[0];
        default:                    cfg.initial_fault    <= cfg.initial_fault;
      endcase
    end
  end

  olc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .operation       (s_axis_tuser),
    .now_ms          (s_axis_tdata[31:0]),
    .motion_seen     (s_axis_tdata[32]),
    .lamp_dark_fault (s_axis_tdata[33]),
    .command_byte    (s_axis_tdata[41:34]),
    .command_length  (s_axis_tdata[47:42]),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  olc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  olc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (pop_valid),
    .item_ready   (pop_ready),
    .item         (pop_item),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_report   (out_report),
    .out_lamp_on  (out_lamp_on),
    .out_override (out_override),
    .out_last     (m_axis_tlast)
  );

  // Pack the result transaction
  assign m_axis_tuser = out_report.kind;
  assign m_axis_tdata = {5'd0, out_override, out_lamp_on, out_report.value};

endmodule

`default_nettype wire

// ===== rtl/olc_front.sv =====
// Front end: registers an accepted transaction and classifies it.
// Ignored commands are dropped here. Depends on olc_pkg.
`default_nettype none

module olc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          operation,
  input  wire logic [31:0]   now_ms,
  input  wire logic          motion_seen,
  input  wire logic          lamp_dark_fault,
  input  wire logic [7:0]    command_byte,
  input  wire logic [5:0]    command_length,
  output logic               push_valid,
  input  wire logic          push_ready,
  output olc_pkg::item_t     push_item
);

  logic           f_valid;
  logic           f_drop;
  olc_pkg::item_t f_item;
  logic           f_drop_next;
  olc_pkg::item_t f_item_next;
  logic           release_item;

  // Classify the incoming transaction
  always_comb begin
    f_item_next.now_ms          = now_ms[olc_pkg::TIME_BITS-1:0];
    f_item_next.motion_seen     = motion_seen;
    f_item_next.lamp_dark_fault = lamp_dark_fault;
    f_item_next.kind            = olc_pkg::ITEM_POLL;
    f_drop_next                 = 1'b0;
    if (operation == olc_pkg::OPERATION_COMMAND) begin
      if (command_length == 6'd0) begin
        f_drop_next = 1'b1;
      end else if (command_byte == olc_pkg::CMD_MANUAL_ON) begin
        f_item_next.kind = olc_pkg::ITEM_MANUAL_ON;
      end else if (command_byte == olc_pkg::CMD_OFF) begin
        f_item_next.kind = olc_pkg::ITEM_OFF;
      end else if (command_byte == olc_pkg::CMD_ON) begin
        f_item_next.kind = olc_pkg::ITEM_ON;
      end else begin
        f_drop_next = 1'b1;
      end
    end
  end

  assign release_item = f_valid && (f_drop || push_ready);
  assign in_ready     = !f_valid || release_item;
  assign push_valid   = f_valid && !f_drop;
  assign push_item    = f_item;

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item <= f_item_next;
      f_drop <= f_drop_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/olc_queue.sv =====
// Short item queue between front and back end.
// Register array with head/tail pointers. Depends on olc_pkg.
`default_nettype none

module olc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire olc_pkg::item_t push_item,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output olc_pkg::item_t     pop_item
);

  olc_pkg::item_t                  slots [olc_pkg::QDEPTH];
  logic [olc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [olc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [olc_pkg::QCNT_W-1:0]      count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != olc_pkg::QCNT_W'(olc_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/olc_back.sv =====
// Back end: applies each item to the lamp, motion and fault state and
// streams out its reports one per cycle while the output is not stalled. Depends on olc_pkg.
`default_nettype none

module olc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire olc_pkg::cfg_t cfg,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire olc_pkg::item_t item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output olc_pkg::report_t   out_report,
  output logic               out_lamp_on,
  output logic               out_override,
  output logic               out_last
);

  // Controller state
  logic                          lamp_state,      lamp_state_next;
  logic                          manual_mode,     manual_mode_next;
  logic [olc_pkg::TIME_BITS-1:0] detect_time,     detect_time_next;
  logic                          motion_reported, motion_reported_next;
  logic                          fault_pending,   fault_pending_next;
  logic [olc_pkg::TIME_BITS-1:0] fault_start_time, fault_start_time_next;
  logic                          fault_latched,   fault_latched_next;
  logic                          fault_loaded,    fault_loaded_next;

  // Report buffer of the item in flight
  olc_pkg::report_t              reps [olc_pkg::MAX_REPORTS];
  olc_pkg::report_t              reps_next [olc_pkg::MAX_REPORTS];
  logic [olc_pkg::REP_CNT_W-1:0] rem;
  logic [olc_pkg::REP_CNT_W-1:0] rep_cnt_next;
  logic [olc_pkg::REP_IDX_W-1:0] idx;
  logic                          buf_lamp;
  logic                          buf_manual;

  logic [olc_pkg::TIME_BITS-1:0] fault_elapsed;
  logic [olc_pkg::TIME_BITS-1:0] detect_elapsed;
  logic                          confirm_due;
  logic                          clear_due;
  logic                          hold_due;
  logic                          latched_now;
  logic                          advance;
  logic                          pop;

  // Wrapping elapsed times against the configured limits
  assign fault_elapsed  = item.now_ms - fault_start_time;
  assign detect_elapsed = item.now_ms - detect_time;
  assign confirm_due = fault_elapsed >= olc_pkg::TIME_BITS'(cfg.fault_confirm_ms);
  assign clear_due   = fault_elapsed >= olc_pkg::TIME_BITS'(cfg.fault_clear_ms);
  assign hold_due    = detect_elapsed >= olc_pkg::TIME_BITS'(cfg.hold_time_ms);
  assign latched_now = fault_loaded ? fault_latched : cfg.initial_fault;

  assign advance    = !out_valid || out_ready;
  assign pop        = item_valid &&
                      ((rem == '0) || ((rem == olc_pkg::REP_CNT_W'(1)) && advance));
  assign item_ready = pop;

  // Apply one item to the state and list its reports
  always_comb begin
    lamp_state_next       = lamp_state;
    manual_mode_next      = manual_mode;
    detect_time_next      = detect_time;
    motion_reported_next  = motion_reported;
    fault_pending_next    = fault_pending;
    fault_start_time_next = fault_start_time;
    fault_latched_next    = fault_latched;
    fault_loaded_next     = fault_loaded;
    rep_cnt_next          = '0;
    for (int i = 0; i < olc_pkg::MAX_REPORTS; i++) begin
      reps_next[i].kind  = olc_pkg::REPORT_LAMP;
      reps_next[i].value = 1'b0;
    end
    unique case (item.kind)
      olc_pkg::ITEM_POLL: begin
        fault_loaded_next  = 1'b1;
        fault_latched_next = latched_now;
        // Debounce the lamp-dark fault
        if (item.lamp_dark_fault) begin
          if (!fault_pending) begin
            fault_pending_next    = 1'b1;
            fault_start_time_next = item.now_ms;
          end else if (confirm_due && !latched_now) begin
            reps_next[rep_cnt_next[olc_pkg::REP_IDX_W-1:0]] = '{olc_pkg::REPORT_FAULT, 1'b1};
            rep_cnt_next       = rep_cnt_next + 1'b1;
            fault_latched_next = 1'b1;
          end
        end else if (latched_now && clear_due) begin
          reps_next[rep_cnt_next[olc_pkg::REP_IDX_W-1:0]] = '{olc_pkg::REPORT_FAULT, 1'b0};
          rep_cnt_next       = rep_cnt_next + 1'b1;
          fault_pending_next = 1'b0;
          fault_latched_next = 1'b0;
        end
        // Automatic occupancy control
        if (!manual_mode) begin
          if (item.motion_seen) begin
            detect_time_next = item.now_ms;
            if (!motion_reported) begin
              reps_next[rep_cnt_next[olc_pkg::REP_IDX_W-1:0]] =
                '{olc_pkg::REPORT_MOTION, 1'b1};
              rep_cnt_next         = rep_cnt_next + 1'b1;
              motion_reported_next = 1'b1;
            end
            if (!lamp_state) begin
              reps_next[rep_cnt_next[olc_pkg::REP_IDX_W-1:0]] = '{olc_pkg::REPORT_LAMP, 1'b1};
              rep_cnt_next    = rep_cnt_next + 1'b1;
              lamp_state_next = 1'b1;
            end
          end else if (lamp_state && hold_due) begin
            reps_next[rep_cnt_next[olc_pkg::REP_IDX_W-1:0]] = '{olc_pkg::REPORT_LAMP, 1'b0};
            rep_cnt_next         = rep_cnt_next + 1'b1;
            lamp_state_next      = 1'b0;
            motion_reported_next = 1'b0;
          end
        end
      end
      olc_pkg::ITEM_MANUAL_ON: begin
        manual_mode_next = 1'b1;
        lamp_state_next  = 1'b1;
        if (!lamp_state) begin
          reps_next[0] = '{olc_pkg::REPORT_LAMP, 1'b1};
          rep_cnt_next = olc_pkg::REP_CNT_W'(1);
        end
      end
      olc_pkg::ITEM_OFF: begin
        manual_mode_next = 1'b0;
        lamp_state_next  = 1'b0;
        if (lamp_state) begin
          reps_next[0] = '{olc_pkg::REPORT_LAMP, 1'b0};
          rep_cnt_next = olc_pkg::REP_CNT_W'(1);
        end
      end
      olc_pkg::ITEM_ON: begin
        lamp_state_next = 1'b1;
        if (!lamp_state) begin
          reps_next[0] = '{olc_pkg::REPORT_LAMP, 1'b1};
          rep_cnt_next = olc_pkg::REP_CNT_W'(1);
        end
      end
      default: begin
        lamp_state_next = lamp_state;
      end
    endcase
  end

  // Commit state on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_state       <= 1'b0;
      manual_mode      <= 1'b0;
      detect_time      <= '0;
      motion_reported  <= 1'b0;
      fault_pending    <= 1'b0;
      fault_start_time <= '0;
      fault_latched    <= 1'b0;
      fault_loaded     <= 1'b0;
    end else if (pop) begin
      lamp_state       <= lamp_state_next;
      manual_mode      <= manual_mode_next;
      detect_time      <= detect_time_next;
      motion_reported  <= motion_reported_next;
      fault_pending    <= fault_pending_next;
      fault_start_time <= fault_start_time_next;
      fault_latched    <= fault_latched_next;
      fault_loaded     <= fault_loaded_next;
    end
  end

  // Drain the report buffer into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= (rem != '0);
      end
      if (advance && (rem != '0)) begin
        rem <= rem - 1'b1;
        idx <= idx + 1'b1;
      end
      if (pop) begin
        rem <= rep_cnt_next;
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (rem != '0)) begin
      out_report   <= reps[idx];
      out_lamp_on  <= buf_lamp;
      out_override <= buf_manual;
      out_last     <= (rem == olc_pkg::REP_CNT_W'(1));
    end
    if (pop) begin
      reps       <= reps_next;
      buf_lamp   <= lamp_state_next;
      buf_manual <= manual_mode_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/occupancy_lamp_controller_unit_tb.sv =====
// Self-checking testbench of occupancy_lamp_controller_unit: directed and random
// polls and lamp commands under random stalls, checked against a local predictor.
// Depends on olc_pkg and the occupancy_lamp_controller_unit RTL.
`default_nettype none

module occupancy_lamp_controller_unit_tb;

  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_SHOWN       = 10;

  // One report as it leaves the block
  typedef struct packed {
    olc_pkg::report_kind_t kind;
    logic                  value;
    logic                  lamp_on;
    logic                  manual_on;
    logic                  last;
  } lamp_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predicted controller state and register copies
  logic        lamp_lit = 1'b0;
  logic        in_manual = 1'b0;
  logic [31:0] last_motion_ms = '0;
  logic        motion_told = 1'b0;
  logic        dark_pending = 1'b0;
  logic [31:0] dark_start_ms = '0;
  logic        dark_latched = 1'b0;
  logic        latch_primed = 1'b0;
  logic [15:0] hold_ms = olc_pkg::HOLD_TIME_RESET;
  logic [15:0] confirm_ms = olc_pkg::FAULT_CONFIRM_RESET;
  logic [15:0] clear_ms = olc_pkg::FAULT_CLEAR_RESET;
  logic        fault_at_start = 1'b0;

  lamp_report_t expected_reports[$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;
  int           sender_burst = 0;
  int           sink_burst = 0;
  logic         hold_request = 1'b0;
  logic [31:0]  clock_ms = '0;

  occupancy_lamp_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draw a wait in cycles; now and then run a stretch with no waits at all
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [31:0] ms_since(input logic [31:0] now_ms,
                                           input logic [31:0] then_ms);
    return now_ms - then_ms;
  endfunction

  // Advance the predicted state by one item and queue the reports it causes
  function automatic void predict_reports(input logic op, input logic [31:0] now_ms,
                                          input logic motion, input logic dark,
                                          input logic [7:0] cmd, input logic [5:0] len);
    olc_pkg::report_kind_t kinds[3];
    logic                  vals[3];
    int                    n;
    int                    k;
    logic                  changed;
    lamp_report_t          r;
    n = 0;
    changed = 1'b0;
    if (op == olc_pkg::OPERATION_POLL) begin
      if (!latch_primed) begin
        dark_latched = fault_at_start;
        latch_primed = 1'b1;
      end
      // Debounce the lamp-dark fault; an early vanish keeps the pending start
      if (dark) begin
        if (!dark_pending) begin
          dark_pending = 1'b1;
          dark_start_ms = now_ms;
        end else if (ms_since(now_ms, dark_start_ms) >= confirm_ms && !dark_latched) begin
          kinds[n] = olc_pkg::REPORT_FAULT;
          vals[n] = 1'b1;
          n++;
          dark_latched = 1'b1;
        end
      end else if (dark_latched && ms_since(now_ms, dark_start_ms) >= clear_ms) begin
        kinds[n] = olc_pkg::REPORT_FAULT;
        vals[n] = 1'b0;
        n++;
        dark_pending = 1'b0;
        dark_latched = 1'b0;
      end
      // Occupancy control runs only outside manual override
      if (!in_manual) begin
        if (motion) begin
          last_motion_ms = now_ms;
          if (!motion_told) begin
            kinds[n] = olc_pkg::REPORT_MOTION;
            vals[n] = 1'b1;
            n++;
            motion_told = 1'b1;
          end
          if (!lamp_lit) begin
            lamp_lit = 1'b1;
            kinds[n] = olc_pkg::REPORT_LAMP;
            vals[n] = 1'b1;
            n++;
          end
        end else if (lamp_lit && ms_since(now_ms, last_motion_ms) >= hold_ms) begin
          lamp_lit = 1'b0;
          kinds[n] = olc_pkg::REPORT_LAMP;
          vals[n] = 1'b0;
          n++;
          motion_told = 1'b0;
        end
      end
    end else if (len != 0) begin
      case (cmd)
        olc_pkg::CMD_MANUAL_ON: begin
          changed = !lamp_lit;
          lamp_lit = 1'b1;
          in_manual = 1'b1;
        end
        olc_pkg::CMD_OFF: begin
          changed = lamp_lit;
          lamp_lit = 1'b0;
          in_manual = 1'b0;
        end
        olc_pkg::CMD_ON: begin
          changed = !lamp_lit;
          lamp_lit = 1'b1;
        end
        default: ;
      endcase
      if (changed) begin
        kinds[n] = olc_pkg::REPORT_LAMP;
        vals[n] = lamp_lit;
        n++;
      end
    end
    for (k = 0; k < n; k++) begin
      r.kind = kinds[k];
      r.value = vals[k];
      r.lamp_on = lamp_lit;
      r.manual_on = in_manual;
      r.last = (k == n - 1);
      expected_reports.push_back(r);
    end
  endfunction

  // Offer one item after a random gap and hold it until the transaction completes
  task automatic send_item(input logic op, input logic [31:0] now_ms, input logic motion,
                           input logic dark, input logic [7:0] cmd, input logic [5:0] len);
    int gap;
    gap = draw_wait(sender_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {len, cmd, dark, motion, now_ms};
    do @(posedge clk); while (!s_axis_tready);
    predict_reports(op, now_ms, motion, dark, cmd, len);
  endtask

  // Command-only fields carry noise on polls, and the other way round
  task automatic send_poll(input logic [31:0] now_ms, input logic motion, input logic dark);
    send_item(olc_pkg::OPERATION_POLL, now_ms, motion, dark, 8'($urandom), 6'($urandom));
  endtask

  task automatic send_command(input logic [7:0] cmd, input logic [5:0] len);
    send_item(olc_pkg::OPERATION_COMMAND, $urandom, 1'($urandom), 1'($urandom), cmd, len);
  endtask

  // Drop valid, wait out every expected report and any silent work behind it
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      olc_pkg::CFG_HOLD_TIME:     hold_ms = value;
      olc_pkg::CFG_FAULT_CONFIRM: confirm_ms = value;
      olc_pkg::CFG_FAULT_CLEAR:   clear_ms = value;
      olc_pkg::CFG_INITIAL_FAULT: fault_at_start = value[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_timers(input logic [15:0] hold, input logic [15:0] confirm,
                                  input logic [15:0] clear);
    settle_block();
    write_reg(olc_pkg::CFG_HOLD_TIME, hold);
    write_reg(olc_pkg::CFG_FAULT_CONFIRM, confirm);
    write_reg(olc_pkg::CFG_FAULT_CLEAR, clear);
  endtask

  // Mostly realistic poll streams with sticky occupancy and fault lines,
  // time steps scaled to the thresholds, rare jumps and a share of commands
  task automatic send_random_items(input int target, input int unsigned span);
    int         done_items;
    int         pick;
    logic       occupied;
    logic       dark;
    logic [7:0] cmd;
    logic [5:0] len;
    done_items = 0;
    occupied = 1'b0;
    dark = 1'b0;
    clock_ms = $urandom;
    while (done_items < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) clock_ms = $urandom;
      else if (pick > 2) clock_ms = clock_ms + $urandom_range(0, span);
      if ($urandom_range(0, 3) == 0) occupied = ~occupied;
      if ($urandom_range(0, 4) == 0) dark = ~dark;
      if ($urandom_range(0, 9) < 7) begin
        send_poll(clock_ms, occupied, dark);
        done_items++;
      end else begin
        case ($urandom_range(0, 3))
          0: cmd = olc_pkg::CMD_MANUAL_ON;
          1: cmd = olc_pkg::CMD_OFF;
          2: cmd = olc_pkg::CMD_ON;
          default: cmd = 8'($urandom);
        endcase
        len = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
        send_command(cmd, len);
        if (len != 0 && (cmd == olc_pkg::CMD_MANUAL_ON || cmd == olc_pkg::CMD_OFF ||
                         cmd == olc_pkg::CMD_ON))
          done_items++;
      end
    end
  endtask

  // Reset timers, fault restored at start, field extremes, every command and case
  task automatic test_directed_sequence();
    write_reg(olc_pkg::CFG_INITIAL_FAULT, 16'd1);
    send_poll(32'd0, 1'b0, 1'b0);
    send_poll(32'd5000, 1'b0, 1'b0);
    send_poll(32'd5100, 1'b1, 1'b0);
    send_poll(32'd5200, 1'b1, 1'b0);
    send_poll(32'd15199, 1'b0, 1'b0);
    send_poll(32'd15200, 1'b0, 1'b0);
    send_poll(32'd20000, 1'b0, 1'b1);
    send_poll(32'd21000, 1'b0, 1'b0);
    send_poll(32'd23000, 1'b1, 1'b1);
    send_poll(32'd24000, 1'b0, 1'b0);
    send_command(olc_pkg::CMD_MANUAL_ON, 6'd1);
    send_poll(32'd40000, 1'b1, 1'b0);
    send_command(olc_pkg::CMD_ON, 6'd32);
    send_command(olc_pkg::CMD_OFF, 6'd63);
    send_command(olc_pkg::CMD_OFF, 6'd1);
    send_command(olc_pkg::CMD_ON, 6'd0);
    send_command(8'h7E, 6'd5);
    send_command(olc_pkg::CMD_MANUAL_ON, 6'd1);
    send_command(olc_pkg::CMD_OFF, 6'd1);
    send_command(olc_pkg::CMD_ON, 6'd1);
    send_poll(32'hFFFF_FF00, 1'b1, 1'b0);
    send_poll(32'h0000_2000, 1'b0, 1'b0);
    send_poll(32'h0000_3000, 1'b0, 1'b0);
    send_poll(32'h0000_3100, 1'b1, 1'b1);
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
  endtask

  task automatic test_zero_timers();
    configure_timers(16'd0, 16'd0, 16'd0);
    send_random_items(60, 4);
  endtask

  task automatic test_max_timers();
    configure_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(olc_pkg::CFG_INITIAL_FAULT, 16'd0);
    send_random_items(60, 131072);
  endtask

  task automatic test_short_timers();
    configure_timers(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                     16'($urandom_range(1, 40)));
    send_random_items(100, 82);
  endtask

  task automatic test_random_timers();
    configure_timers(16'($urandom), 16'($urandom), 16'($urandom));
    send_random_items(60, 131072);
  endtask

  // Stall the output for a long stretch while commands keep the input busy
  task automatic test_output_backpressure();
    int i;
    configure_timers(16'd10000, 16'd3000, 16'd3000);
    hold_request = 1'b1;
    sender_burst = 40;
    for (i = 0; i < 40; i++)
      send_command((i % 2 == 0) ? olc_pkg::CMD_MANUAL_ON : olc_pkg::CMD_OFF,
                   6'($urandom_range(1, 63)));
  endtask

  task automatic test_default_timers();
    configure_timers(olc_pkg::HOLD_TIME_RESET, olc_pkg::FAULT_CONFIRM_RESET,
                     olc_pkg::FAULT_CLEAR_RESET);
    send_random_items(80, 20002);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_sequence();
    test_zero_timers();
    test_max_timers();
    test_short_timers();
    test_random_timers();
    test_output_backpressure();
    test_default_timers();
    settle_block();
    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls per report, one long hold-off on request
  initial begin : report_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = draw_wait(sink_burst);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Compare each output transaction with the oldest expected report
  always @(posedge clk) begin : report_check
    lamp_report_t want;
    lamp_report_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = olc_pkg::report_kind_t'(m_axis_tuser);
      got.value = m_axis_tdata[0];
      got.lamp_on = m_axis_tdata[1];
      got.manual_on = m_axis_tdata[2];
      got.last = m_axis_tlast;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected report: kind %0d value %b lamp %b manual %b last %b",
                   got.kind, got.value, got.lamp_on, got.manual_on, got.last);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want || m_axis_tdata[7:3] !== 5'd0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display({"report mismatch: expected kind %0d value %b lamp %b manual %b ",
                      "last %b, got kind %0d tdata %h last %b"},
                     want.kind, want.value, want.lamp_on, want.manual_on, want.last,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/olc_pkg.sv
rtl/olc_front.sv
rtl/olc_queue.sv
rtl/olc_back.sv
rtl/occupancy_lamp_controller_unit.sv
tb/occupancy_lamp_controller_unit_tb.sv
